@@ rtl/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Word layouts of the scan and result channels, register indexes, defaults.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;

  // Pattern bytes and enable bits held in registers
  localparam int CFG_PATTERN_BYTES = 16;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 64;
  localparam int LENGTH_BITS       = 5;
  localparam int ADDR_BITS         = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_COMPARE_EN   = 3'd2,
    CFG_LENGTH       = 3'd3,
    CFG_BASE_ADDR    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] scan_byte;
    logic       final_byte;
  } scan_word_t;

  typedef struct packed {
    logic                 match_found;
    logic [ADDR_BITS-1:0] match_address;
  } result_word_t;

  // Step control handed from the top level to the hit tracker
  typedef struct packed {
    logic advance;
    logic last;
  } scan_ctl_t;

endpackage

@@ rtl/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell: one pattern position of the prefix match chain
// Holds the prefix bit of its position and compares the scanned byte.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       last,
  input  logic       chain_in,
  input  logic [7:0] scan_byte,
  input  logic [7:0] pattern_byte,
  input  logic       compare_en,
  output logic       prefix,
  output logic       prefix_next
);

  logic accept;

  assign accept      = !compare_en || (pattern_byte == scan_byte);
  assign prefix_next = chain_in && accept;

  // Drop the prefix at the end of a region
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
    end else if (advance) begin
      prefix <= last ? 1'b0 : prefix_next;
    end
  end

endmodule

@@ rtl/mbps_track.sv @@
// ----------------------------------------------------------------------------
// mbps_track: position counter, first hit capture and result register
// Picks the full-length prefix bit, keeps the earliest hit, emits one word.
// ----------------------------------------------------------------------------
module mbps_track #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mbps_pkg::scan_ctl_t                  ctl,
  input  logic [MAX_PATTERN_BYTES-1:0]         prefix_next,
  input  logic [mbps_pkg::LENGTH_BITS-1:0]     pattern_length,
  input  logic [mbps_pkg::ADDR_BITS-1:0]       base_address,
  input  logic                                 result_stall,
  output logic                                 result_valid,
  output mbps_pkg::result_word_t               result_word
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [LEN_W-1:0]       len;
  logic [IDX_W-1:0]       sel;
  logic                   hit_now;
  logic [OFFSET_BITS-1:0] position;
  logic                   seen;
  logic [OFFSET_BITS-1:0] offset;
  logic                   seen_next;
  logic [OFFSET_BITS-1:0] offset_next;

  always_comb begin
    if (32'(pattern_length) > MAX_PATTERN_BYTES) begin
      len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len = LEN_W'(pattern_length);
    end
    sel     = IDX_W'(len - LEN_W'(1));
    hit_now = (len == '0) || prefix_next[sel];
    seen_next = seen || hit_now;
    // Window start is the current position less the pattern length minus one
    if (seen) begin
      offset_next = offset;
    end else if (len == '0) begin
      offset_next = position;
    end else begin
      offset_next = position - OFFSET_BITS'(len - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      seen     <= 1'b0;
      offset   <= '0;
    end else if (ctl.advance) begin
      if (ctl.last) begin
        position <= '0;
        seen     <= 1'b0;
        offset   <= '0;
      end else begin
        position <= position + OFFSET_BITS'(1);
        seen     <= seen_next;
        offset   <= offset_next;
      end
    end
  end

  // Result register: load on the final byte, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.advance && ctl.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.last) begin
      result_word.match_found   <= seen_next;
      result_word.match_address <= seen_next
                                   ? base_address + mbps_pkg::ADDR_BITS'(offset_next)
                                   : '0;
    end
  end

endmodule

@@ rtl/masked_byte_pattern_scanner.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: wildcard byte signature scan
// Finds the first window of the byte stream that matches a masked pattern.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  scan    | in        | scan_valid/stall    | scan_byte, final_byte
//  result  | out       | result_valid/stall  | match_found, match_address
//  cfg     | in        | cfg_valid/ready     | cfg_index, cfg_data
//
//  One scanned byte per cycle while scan_stall is low; the prefix chain updates all positions at once.
//  The result word appears in the cycle after the final byte is taken.
//  scan_stall rises only while a result word sits stalled in the output register.
//  Synchronous reset clears the configuration, the prefix chain and the result valid flag.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                scan_valid,
  output logic                                scan_stall,
  input  mbps_pkg::scan_word_t                scan_word,
  output logic                                result_valid,
  input  logic                                result_stall,
  output mbps_pkg::result_word_t              result_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PAT_BYTES = mbps_pkg::CFG_PATTERN_BYTES;

  logic [8*PAT_BYTES-1:0]             pattern;
  logic [PAT_BYTES-1:0]               compare_en;
  logic [mbps_pkg::LENGTH_BITS-1:0]   pattern_length;
  logic [mbps_pkg::ADDR_BITS-1:0]     base_address;
  logic [MAX_PATTERN_BYTES-1:0]       prefix;
  logic [MAX_PATTERN_BYTES-1:0]       prefix_next;
  mbps_pkg::scan_ctl_t                ctl;

  assign cfg_ready   = 1'b1;
  assign scan_stall  = result_valid && result_stall;
  assign ctl.advance = scan_valid && !scan_stall;
  assign ctl.last    = scan_word.final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      compare_en     <= '0;
      pattern_length <= '0;
      base_address   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mbps_pkg::CFG_PATTERN_LOW:  pattern[63:0]   <= cfg_data;
        mbps_pkg::CFG_PATTERN_HIGH: pattern[127:64] <= cfg_data;
        mbps_pkg::CFG_COMPARE_EN:   compare_en      <= cfg_data[PAT_BYTES-1:0];
        mbps_pkg::CFG_LENGTH:       pattern_length  <= cfg_data[mbps_pkg::LENGTH_BITS-1:0];
        mbps_pkg::CFG_BASE_ADDR:    base_address    <= cfg_data[mbps_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    logic       chain_in;
    logic [7:0] cell_byte;
    logic       cell_en;

    if (i == 0) begin : g_head
      assign chain_in = 1'b1;
    end else begin : g_link
      assign chain_in = prefix[i-1];
    end

    // Positions past the register file act as wildcards
    if (i < PAT_BYTES) begin : g_cfg
      assign cell_byte = pattern[8*i +: 8];
      assign cell_en   = compare_en[i];
    end else begin : g_wild
      assign cell_byte = 8'h00;
      assign cell_en   = 1'b0;
    end

    mbps_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (ctl.advance),
      .last         (ctl.last),
      .chain_in     (chain_in),
      .scan_byte    (scan_word.scan_byte),
      .pattern_byte (cell_byte),
      .compare_en   (cell_en),
      .prefix       (prefix[i]),
      .prefix_next  (prefix_next[i])
    );
  end

  mbps_track #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .prefix_next    (prefix_next),
    .pattern_length (pattern_length),
    .base_address   (base_address),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .result_word    (result_word)
  );

endmodule

@@ rtl/mbps_checker.sv @@
// ----------------------------------------------------------------------------
// mbps_checker: port-level checks of the masked byte pattern scanner
// Watches the scan and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module mbps_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   scan_valid,
  input logic                   scan_stall,
  input mbps_pkg::scan_word_t   scan_word,
  input logic                   result_valid,
  input logic                   result_stall,
  input mbps_pkg::result_word_t result_word
);

  // Scan input holds back only behind a stalled result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    scan_stall |-> (result_valid && result_stall))
    else $error("scan stalled without a stalled result word");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result_word)))
    else $error("stalled result word changed");

  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    (scan_valid && !scan_stall && scan_word.final_byte) |=> result_valid)
    else $error("final byte taken without a result word");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid && result_stall))
      |-> $past(scan_valid && !scan_stall && scan_word.final_byte))
    else $error("result word without a final byte");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_word.match_found) |-> (result_word.match_address == '0))
    else $error("address nonzero on a miss");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk          (clk),
  .rst          (rst),
  .scan_valid   (scan_valid),
  .scan_stall   (scan_stall),
  .scan_word    (scan_word),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);

@@ tb/sv/masked_byte_pattern_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb: self-checking bench for the pattern scanner
// Streams byte regions through the scan channel, and a local tracker of the
// prefix chain predicts each result word. The results are compared field by
// field. Directed cases come first, then random regions with planted patterns,
// under several pattern setups and random stalls on both sides.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;

  localparam int          PAT_MAX      = mbps_pkg::MAX_PATTERN_BYTES_DEF;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   scan_valid   = 1'b0;
  logic                   scan_stall;
  mbps_pkg::scan_word_t   scan_word    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  mbps_pkg::result_word_t result_word;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

  masked_byte_pattern_scanner uut (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .scan_word    (scan_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the registers
  logic [63:0] pat_lo    = '0;
  logic [63:0] pat_hi    = '0;
  logic [15:0] cmp_en    = '0;
  logic [4:0]  pat_len   = '0;
  logic [31:0] base_addr = '0;

  // Shadow copy of the scan state
  logic [PAT_MAX-1:0] prefix_bits = '0;
  logic [31:0]        byte_pos    = '0;
  logic               hit_seen    = 1'b0;
  logic [31:0]        hit_ofs     = '0;

  mbps_pkg::result_word_t pending_matches[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned bytes_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned configs_loaded = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_mark     = 0;
  bit          stall_drawn    = 1'b0;
  bit          steady_sender  = 1'b0;
  bit          steady_receiver = 1'b0;

  function automatic logic [7:0] pattern_byte(int k);
    logic [127:0] all;
    all = {pat_hi, pat_lo};
    return all[k*8 +: 8];
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h78;
      3: return 8'h5A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Advance the prefix chain by one byte; queue a result on the final byte
  function automatic void track_scan_byte(mbps_pkg::scan_word_t w);
    logic [PAT_MAX-1:0]     accept;
    logic [127:0]           all;
    logic [4:0]             len;
    mbps_pkg::result_word_t r;
    all = {pat_hi, pat_lo};
    for (int i = 0; i < PAT_MAX; i++)
      accept[i] = !cmp_en[i] || (all[i*8 +: 8] == w.scan_byte);
    len = (pat_len > 5'(PAT_MAX)) ? 5'(PAT_MAX) : pat_len;
    prefix_bits = {prefix_bits[PAT_MAX-2:0], 1'b1} & accept;
    if (!hit_seen) begin
      if (len == 5'd0) begin
        hit_seen = 1'b1;
        hit_ofs  = byte_pos;
      end else if (prefix_bits[len - 5'd1]) begin
        hit_seen = 1'b1;
        hit_ofs  = byte_pos - {27'd0, len} + 32'd1;
      end
    end
    byte_pos = byte_pos + 32'd1;
    if (w.final_byte) begin
      r.match_found   = hit_seen;
      r.match_address = hit_seen ? base_addr + hit_ofs : 32'd0;
      pending_matches.push_back(r);
      prefix_bits = '0;
      byte_pos    = '0;
      hit_seen    = 1'b0;
      hit_ofs     = '0;
    end
  endfunction

  task automatic write_reg(input mbps_pkg::cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mbps_pkg::CFG_PATTERN_LOW:  pat_lo    = val;
      mbps_pkg::CFG_PATTERN_HIGH: pat_hi    = val;
      mbps_pkg::CFG_COMPARE_EN:   cmp_en    = val[15:0];
      mbps_pkg::CFG_LENGTH:       pat_len   = val[4:0];
      mbps_pkg::CFG_BASE_ADDR:    base_addr = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Unused upper data bits carry noise; the registers keep only their width
  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] en, input logic [4:0] len,
                              input logic [31:0] base);
    logic [63:0] noise;
    write_reg(mbps_pkg::CFG_PATTERN_LOW, lo);
    write_reg(mbps_pkg::CFG_PATTERN_HIGH, hi);
    noise = {$urandom, $urandom};
    write_reg(mbps_pkg::CFG_COMPARE_EN, {noise[63:16], en});
    noise = {$urandom, $urandom};
    write_reg(mbps_pkg::CFG_LENGTH, {noise[63:5], len});
    noise = {$urandom, $urandom};
    write_reg(mbps_pkg::CFG_BASE_ADDR, {noise[63:32], base});
    configs_loaded++;
  endtask

  // Valid stays high after acceptance until the next call lowers or reuses it
  task automatic send_scan(input logic [7:0] b, input logic fin);
    int unsigned          gap;
    mbps_pkg::scan_word_t w;
    gap = steady_sender ? 0 : $urandom_range(0, 16);
    w.scan_byte  = b;
    w.final_byte = fin;
    @(negedge clk);
    if (gap != 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    scan_valid <= 1'b1;
    scan_word  <= w;
    do @(posedge clk); while (scan_stall);
    track_scan_byte(w);
    bytes_sent++;
  endtask

  // Hold off the sender until every result word is back
  task automatic settle_block();
    @(negedge clk);
    scan_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_pattern();
    send_scan(8'h00, 1'b1);
    settle_block();
  endtask

  // A window that would run past the final byte must not count
  task automatic test_window_past_end();
    load_pattern(64'h0000_0000_0033_2211, 64'h0, 16'hFFFF, 5'd3, 32'h0000_0100);
    send_scan(8'h11, 1'b0);
    send_scan(8'h22, 1'b1);
    settle_block();
  endtask

  task automatic test_address_wrap();
    load_pattern(64'h0000_0000_0000_00FF, 64'h0, 16'h0001, 5'd1, 32'hFFFF_FFFF);
    send_scan(8'h00, 1'b0);
    send_scan(8'hFF, 1'b1);
    settle_block();
  endtask

  task automatic test_wildcard_positions();
    load_pattern(64'h0000_0000_0078_0078, 64'h0, 16'h0005, 5'd3, 32'h8000_0000);
    send_scan(8'h41, 1'b0);
    send_scan(8'h78, 1'b0);
    send_scan(8'h00, 1'b0);
    send_scan(8'h78, 1'b1);
    settle_block();
  endtask

  // Oversized length clips to the full pattern, spanning both byte registers
  task automatic test_length_saturation();
    load_pattern(64'h8877_6655_4433_2211, 64'hFFEE_DDCC_BBAA_9900, 16'hFFFF, 5'd31,
                 32'h0000_1000);
    for (int k = 0; k < PAT_MAX; k++) send_scan(pattern_byte(k), k == PAT_MAX - 1);
    settle_block();
  endtask

  task automatic random_setup(input int unsigned phase);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] en;
    logic [4:0]  len;
    logic [31:0] base;
    for (int k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = pick_byte();
      hi[k*8 +: 8] = pick_byte();
    end
    en   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    len  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                                         5'($urandom_range(1, 6));
    base = $urandom;
    case (phase)
      0: begin
        lo = '1; hi = '1; en = 16'hFFFF; len = 5'd16; base = '1;
      end
      1: begin
        lo = '0; hi = '0; en = 16'h0000; len = 5'd0; base = '0;
      end
      2: begin
        en = 16'hFFFF; len = 5'd31; base = 32'hFFFF_FFF0;
      end
      3: begin
        en = 16'h0000; len = 5'($urandom_range(1, 16));
      end
      default: ;
    endcase
    load_pattern(lo, hi, en, len, base);
  endtask

  // Mostly regions with a planted copy of the pattern, some with one byte broken
  task automatic scan_random_region();
    logic [7:0]  region[$];
    int unsigned n;
    int unsigned at;
    int unsigned eff;
    int unsigned k;
    bit          plant;
    eff   = (pat_len > 5'(PAT_MAX)) ? PAT_MAX : pat_len;
    n     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 20);
    plant = ($urandom_range(0, 9) < 6) && (eff != 0);
    if (plant && n < eff) n = eff;
    for (k = 0; k < n; k++) region.push_back(pick_byte());
    if (plant) begin
      at = $urandom_range(0, n - eff);
      for (k = 0; k < eff; k++)
        if (cmp_en[k]) region[at + k] = pattern_byte(k);
      if ($urandom_range(0, 3) == 0) begin
        k = at + $urandom_range(0, eff - 1);
        region[k] = region[k] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
    steady_sender   = ($urandom_range(0, 4) == 0);
    steady_receiver = ($urandom_range(0, 4) == 0);
    for (k = 0; k < n; k++) send_scan(region[k], k == n - 1);
  endtask

  task automatic test_random_regions();
    int unsigned phase;
    int unsigned start;
    int unsigned phase_start;
    phase = 0;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      random_setup(phase);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 60) scan_random_region();
      settle_block();
      phase++;
    end
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
  endtask

  // Draw a stall length once per result word, starting when it shows up
  always @(negedge clk) begin
    if (results_seen != stall_mark) begin
      stall_mark  = results_seen;
      stall_drawn = 1'b0;
    end
    if (!rst && result_valid && !stall_drawn) begin
      stall_left  = steady_receiver ? 0 : $urandom_range(0, 16);
      stall_drawn = 1'b1;
    end
    result_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin : check_results
    mbps_pkg::result_word_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word %h", $time, result_word);
      end else begin
        want = pending_matches.pop_front();
        if (result_word.match_found !== want.match_found) begin
          mismatches++;
          $display("%0t: match_found expected %0b actual %0b", $time,
                   want.match_found, result_word.match_found);
        end
        if (result_word.match_address !== want.match_address) begin
          mismatches++;
          $display("%0t: match_address expected %h actual %h", $time,
                   want.match_address, result_word.match_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result words still pending", $time,
               pending_matches.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_pattern();
    test_window_past_end();
    test_address_wrap();
    test_wildcard_positions();
    test_length_saturation();
    test_random_regions();
    repeat (8) @(posedge clk);
    $display("Scanned %0d bytes under %0d pattern setups; checked %0d result words",
             bytes_sent, configs_loaded, results_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
